>>> rtl/urf_pkg.sv
package urf_pkg;

  // Field widths of the ports.
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 64;
  localparam int RADIX_W = 5;
  localparam int LEN_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int CFG_IDX_W = 2;

  // Default sizing of the block.
  localparam int DEF_VALUE_BITS = 64;
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_RADIX  = 16;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Conversion codes.
  localparam logic [CMD_W-1:0] CMD_OCT       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEC       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HEX_LOWER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HEX_UPPER = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POINTER   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CUSTOM    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd2;

  // ASCII characters used by the formatter.
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

  // One classified conversion as it travels from front to back.
  typedef struct packed {
    logic               err;
    logic               upper;
    logic               custom;
    logic [RADIX_W-1:0] radix;
    logic [LEN_W-1:0]   width;
    logic               lj;
    logic               zp;
    logic [1:0]         np;
    logic [CHAR_W-1:0]  pre1;
  } urf_desc_t;

  // Built-in digit symbols: 0-9 then a-f or A-F.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] idx,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (idx < DIGIT_W'(10)) begin
      return CH_ZERO + CHAR_W'(idx);
    end
    return base + CHAR_W'(idx) - CHAR_W'(10);
  endfunction

endpackage

>>> rtl/unsigned_radix_formatter.sv
// Channel   Handshake                 Payload
// input     start, busy (start&!busy) in_cmd, in_value, in_radix, in_field_width,
//                                     in_left_justify, in_zero_pad, in_alt_prefix
// result    out_valid, one cycle      out_char, out_last, out_total_length, out_error
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// Steps: the back end takes an item from the queue, then works out each digit by a pass
// of byte-wide restoring division over the value, lays the text out and then emits its
// characters. Each character and an error result appear in the cycle after they are formed.
// The receiver cannot stall results; busy rises only when the front stage and queue are
// full. Reset is synchronous, active low, and empties the pipeline and clears the
// configuration registers.
module unsigned_radix_formatter #(
  parameter int VALUE_BITS = urf_pkg::DEF_VALUE_BITS,
  parameter int MAX_WIDTH  = urf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIX  = urf_pkg::DEF_MAX_RADIX
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [urf_pkg::CMD_W-1:0]      in_cmd,
  input  logic [urf_pkg::VALUE_W-1:0]    in_value,
  input  logic [urf_pkg::RADIX_W-1:0]    in_radix,
  input  logic [urf_pkg::LEN_W-1:0]      in_field_width,
  input  logic                           in_left_justify,
  input  logic                           in_zero_pad,
  input  logic                           in_alt_prefix,
  output logic                           out_valid,
  output logic [urf_pkg::CHAR_W-1:0]     out_char,
  output logic                           out_last,
  output logic [urf_pkg::LEN_W-1:0]      out_total_length,
  output logic                           out_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [urf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urf_pkg::VALUE_W-1:0]    cfg_data
);

  logic [urf_pkg::VALUE_W-1:0] sym_low_r;
  logic [urf_pkg::VALUE_W-1:0] sym_high_r;
  logic [urf_pkg::RADIX_W-1:0] custom_radix_r;

  logic                        push;
  urf_pkg::urf_desc_t          push_desc;
  logic [VALUE_BITS-1:0]       push_value;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_valid;
  urf_pkg::urf_desc_t          q_desc;
  logic [VALUE_BITS-1:0]       q_value;

  // Configuration registers; writes to an unused index are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_low_r      <= '0;
      sym_high_r     <= '0;
      custom_radix_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        urf_pkg::CFG_SYM_LOW:  sym_low_r      <= cfg_data;
        urf_pkg::CFG_SYM_HIGH: sym_high_r     <= cfg_data;
        urf_pkg::CFG_RADIX:    custom_radix_r <= cfg_data[urf_pkg::RADIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front stage: accept and classify.
  urf_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIX (MAX_RADIX)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .in_field_width (in_field_width),
    .in_left_justify(in_left_justify),
    .in_zero_pad    (in_zero_pad),
    .in_alt_prefix  (in_alt_prefix),
    .custom_radix   (custom_radix_r),
    .q_full         (q_full),
    .push           (push),
    .push_desc      (push_desc),
    .push_value     (push_value)
  );

  // Queue between the two halves.
  urf_queue #(
    .VALUE_BITS(VALUE_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .push_value(push_value),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_desc  (q_desc),
    .pop_value (q_value)
  );

  // Back end: digit generation and character output.
  urf_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_desc          (q_desc),
    .q_value         (q_value),
    .q_pop           (q_pop),
    .sym_low         (sym_low_r),
    .sym_high        (sym_high_r),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_last        (out_last),
    .out_total_length(out_total_length),
    .out_error       (out_error)
  );

endmodule

>>> rtl/urf_front.sv
module urf_front #(
  parameter int VALUE_BITS = urf_pkg::DEF_VALUE_BITS,
  parameter int MAX_WIDTH  = urf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIX  = urf_pkg::DEF_MAX_RADIX
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [urf_pkg::CMD_W-1:0]    in_cmd,
  input  logic [urf_pkg::VALUE_W-1:0]  in_value,
  input  logic [urf_pkg::RADIX_W-1:0]  in_radix,
  input  logic [urf_pkg::LEN_W-1:0]    in_field_width,
  input  logic                         in_left_justify,
  input  logic                         in_zero_pad,
  input  logic                         in_alt_prefix,
  input  logic [urf_pkg::RADIX_W-1:0]  custom_radix,
  input  logic                         q_full,
  output logic                         push,
  output urf_pkg::urf_desc_t           push_desc,
  output logic [VALUE_BITS-1:0]        push_value
);

  logic                         hold_r;
  urf_pkg::urf_desc_t           desc_r;
  urf_pkg::urf_desc_t           desc_nxt;
  logic [VALUE_BITS-1:0]        value_r;
  logic                         accept;
  logic                         value_nz;
  logic                         want_pre;
  logic [urf_pkg::RADIX_W-1:0]  radix_eff;
  logic                         cmd_bad;

  // The holding stage frees up in the same cycle that it hands its item on.
  assign push   = hold_r && !q_full;
  assign busy   = hold_r && q_full;
  assign accept = start && !busy;

  assign push_desc  = desc_r;
  assign push_value = value_r;

  // Classify the incoming conversion.
  assign value_nz  = |in_value[VALUE_BITS-1:0];
  assign want_pre  = (in_cmd == urf_pkg::CMD_POINTER) || (in_alt_prefix && value_nz);
  assign radix_eff = (in_cmd == urf_pkg::CMD_CUSTOM) ? custom_radix : in_radix;

  always_comb begin
    cmd_bad        = 1'b0;
    desc_nxt.np    = 2'd0;
    desc_nxt.pre1  = urf_pkg::CH_LOWER_X;
    desc_nxt.upper = 1'b0;
    desc_nxt.custom = 1'b0;
    unique case (in_cmd) inside
      urf_pkg::CMD_OCT: begin
        desc_nxt.np = want_pre ? 2'd1 : 2'd0;
      end
      urf_pkg::CMD_DEC: begin
        desc_nxt.np = 2'd0;
      end
      urf_pkg::CMD_HEX_LOWER, urf_pkg::CMD_POINTER: begin
        desc_nxt.np = want_pre ? 2'd2 : 2'd0;
      end
      urf_pkg::CMD_HEX_UPPER: begin
        desc_nxt.np    = want_pre ? 2'd2 : 2'd0;
        desc_nxt.pre1  = urf_pkg::CH_UPPER_X;
        desc_nxt.upper = 1'b1;
      end
      urf_pkg::CMD_CUSTOM: begin
        desc_nxt.custom = 1'b1;
      end
      default: begin
        cmd_bad = 1'b1;
      end
    endcase
    desc_nxt.err   = cmd_bad || (radix_eff < urf_pkg::RADIX_W'(2)) ||
                     (radix_eff > urf_pkg::RADIX_W'(MAX_RADIX));
    desc_nxt.radix = radix_eff;
    desc_nxt.width = (in_field_width > urf_pkg::LEN_W'(MAX_WIDTH)) ?
                     urf_pkg::LEN_W'(MAX_WIDTH) : in_field_width;
    desc_nxt.lj    = in_left_justify;
    desc_nxt.zp    = in_zero_pad;
  end

  // Holding stage occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (accept) begin
      hold_r <= 1'b1;
    end else if (push) begin
      hold_r <= 1'b0;
    end
  end

  // Holding stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r  <= desc_nxt;
      value_r <= in_value[VALUE_BITS-1:0];
    end
  end

endmodule

>>> rtl/urf_queue.sv
module urf_queue #(
  parameter int VALUE_BITS = urf_pkg::DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  urf_pkg::urf_desc_t    push_desc,
  input  logic [VALUE_BITS-1:0] push_value,
  output logic                  full,
  input  logic                  pop,
  output logic                  pop_valid,
  output urf_pkg::urf_desc_t    pop_desc,
  output logic [VALUE_BITS-1:0] pop_value
);

  localparam int DEPTH = urf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  urf_pkg::urf_desc_t    desc_r  [DEPTH];
  logic [VALUE_BITS-1:0] value_r [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r;
  logic [PTR_W-1:0]      rd_ptr_r;
  logic [CNT_W-1:0]      cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_desc  = desc_r[rd_ptr_r];
  assign pop_value = value_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      desc_r[wr_ptr_r]  <= push_desc;
      value_r[wr_ptr_r] <= push_value;
    end
  end

endmodule

>>> rtl/urf_back.sv
module urf_back #(
  parameter int VALUE_BITS = urf_pkg::DEF_VALUE_BITS,
  parameter int MAX_WIDTH  = urf_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  urf_pkg::urf_desc_t           q_desc,
  input  logic [VALUE_BITS-1:0]        q_value,
  output logic                         q_pop,
  input  logic [urf_pkg::VALUE_W-1:0]  sym_low,
  input  logic [urf_pkg::VALUE_W-1:0]  sym_high,
  output logic                         out_valid,
  output logic [urf_pkg::CHAR_W-1:0]   out_char,
  output logic                         out_last,
  output logic [urf_pkg::LEN_W-1:0]    out_total_length,
  output logic                         out_error
);

  localparam int DIV_BYTES = (VALUE_BITS + 7) / 8;
  localparam int DIV_BITS  = DIV_BYTES * 8;
  localparam int BC_W      = (DIV_BYTES > 1) ? $clog2(DIV_BYTES) : 1;
  localparam int LEN_W     = urf_pkg::LEN_W;
  localparam int DIGIT_W   = urf_pkg::DIGIT_W;
  localparam int CHAR_W    = urf_pkg::CHAR_W;
  localparam int RADIX_W   = urf_pkg::RADIX_W;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_DIV   = 4'b0010,
    B_SETUP = 4'b0100,
    B_EMIT  = 4'b1000
  } back_state_t;

  back_state_t                          state_r;
  urf_pkg::urf_desc_t                   desc_r;
  logic [DIV_BITS-1:0]                  work_r;
  logic [DIV_BITS-1:0]                  work_nxt;
  logic [DIGIT_W-1:0]                   rem_r;
  logic [DIGIT_W-1:0]                   rem_nxt;
  logic [BC_W-1:0]                      byte_cnt_r;
  logic                                 qnz_r;
  logic [LEN_W-1:0]                     nd_r;
  logic [VALUE_BITS-1:0][DIGIT_W-1:0]   dig_r;
  logic [LEN_W-1:0]                     lead_r;
  logic [LEN_W-1:0]                     pre_r;
  logic [LEN_W-1:0]                     zero_r;
  logic [LEN_W-1:0]                     dig_end_r;
  logic [LEN_W-1:0]                     emit_r;
  logic [LEN_W-1:0]                     pos_r;
  logic                                 out_valid_r;
  logic [CHAR_W-1:0]                    out_char_r;
  logic                                 out_last_r;
  logic [LEN_W-1:0]                     out_len_r;
  logic                                 out_error_r;

  logic [7:0]                           quo_byte;
  logic                                 pass_done;
  logic                                 quo_nz;
  logic [LEN_W-1:0]                     size;
  logic [LEN_W-1:0]                     total;
  logic [LEN_W-1:0]                     pad;
  logic [LEN_W-1:0]                     lead;
  logic [LEN_W-1:0]                     zeros;
  logic [CHAR_W-1:0]                    emit_char;
  logic                                 in_digits;
  logic                                 emit_last;
  logic [DIGIT_W-1:0]                   top_digit;
  logic [2*urf_pkg::VALUE_W-1:0]        sym_all;

  assign q_pop            = (state_r == B_IDLE) && q_valid;
  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_last         = out_last_r;
  assign out_total_length = out_len_r;
  assign out_error        = out_error_r;

  // Eight restoring division steps per cycle on the top byte of the dividend.
  always_comb begin
    logic [7:0]         top_byte;
    logic [RADIX_W-1:0] trial;
    logic [DIGIT_W-1:0] rem;
    top_byte = work_r[DIV_BITS-1 -: 8];
    rem      = rem_r;
    quo_byte = '0;
    for (int k = 7; k >= 0; k--) begin
      trial = {rem, top_byte[k]};
      if (trial >= desc_r.radix) begin
        trial       = trial - desc_r.radix;
        quo_byte[k] = 1'b1;
      end
      rem = trial[DIGIT_W-1:0];
    end
    rem_nxt  = rem;
    work_nxt = (work_r << 8) | DIV_BITS'(quo_byte);
  end

  assign pass_done = (byte_cnt_r == BC_W'(DIV_BYTES - 1));
  assign quo_nz    = qnz_r || (|quo_byte);

  // Layout of the text: leading spaces, prefix, zeros, digits, trailing spaces.
  always_comb begin
    size  = nd_r + LEN_W'(desc_r.np);
    total = (size > desc_r.width) ? size : desc_r.width;
    pad   = total - size;
    lead  = (!desc_r.lj && !desc_r.zp) ? pad : '0;
    zeros = (!desc_r.lj &&  desc_r.zp) ? pad : '0;
  end

  // Character at the current position.
  assign sym_all   = {sym_high, sym_low};
  assign top_digit = dig_r[VALUE_BITS-1];

  always_comb begin
    in_digits = 1'b0;
    if (pos_r < lead_r) begin
      emit_char = urf_pkg::CH_SPACE;
    end else if (pos_r < pre_r) begin
      emit_char = (pos_r == lead_r) ? urf_pkg::CH_ZERO : desc_r.pre1;
    end else if (pos_r < zero_r) begin
      emit_char = urf_pkg::CH_ZERO;
    end else if (pos_r < dig_end_r) begin
      in_digits = 1'b1;
      emit_char = desc_r.custom ? sym_all[{top_digit, 3'b000} +: CHAR_W] :
                  urf_pkg::digit_char(top_digit, desc_r.upper);
    end else begin
      emit_char = urf_pkg::CH_SPACE;
    end
  end

  assign emit_last = (pos_r + 1'b1 == emit_r);

  // Sequencer and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            if (q_desc.err) begin
              out_valid_r <= 1'b1;
            end else begin
              state_r <= B_DIV;
            end
          end
        end
        B_DIV: begin
          if (pass_done && !quo_nz) begin
            state_r <= B_SETUP;
          end
        end
        B_SETUP: begin
          state_r <= B_EMIT;
        end
        B_EMIT: begin
          out_valid_r <= 1'b1;
          if (emit_last) begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          desc_r      <= q_desc;
          work_r      <= DIV_BITS'(q_value);
          rem_r       <= '0;
          byte_cnt_r  <= '0;
          qnz_r       <= 1'b0;
          nd_r        <= '0;
          out_char_r  <= urf_pkg::CH_NUL;
          out_last_r  <= 1'b1;
          out_len_r   <= '0;
          out_error_r <= 1'b1;
        end
      end
      B_DIV: begin
        work_r <= work_nxt;
        if (pass_done) begin
          dig_r      <= {rem_nxt, dig_r[VALUE_BITS-1:1]};
          nd_r       <= nd_r + 1'b1;
          rem_r      <= '0;
          byte_cnt_r <= '0;
          qnz_r      <= 1'b0;
        end else begin
          rem_r      <= rem_nxt;
          byte_cnt_r <= byte_cnt_r + 1'b1;
          qnz_r      <= quo_nz;
        end
      end
      B_SETUP: begin
        lead_r    <= lead;
        pre_r     <= lead + LEN_W'(desc_r.np);
        zero_r    <= lead + LEN_W'(desc_r.np) + zeros;
        dig_end_r <= lead + LEN_W'(desc_r.np) + zeros + nd_r;
        emit_r    <= (total > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : total;
        pos_r     <= '0;
      end
      B_EMIT: begin
        out_char_r  <= emit_char;
        out_last_r  <= emit_last;
        out_len_r   <= emit_last ? emit_r : '0;
        out_error_r <= 1'b0;
        pos_r       <= pos_r + 1'b1;
        if (in_digits) begin
          dig_r <= {dig_r[VALUE_BITS-2:0], DIGIT_W'(0)};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  // With nothing to start, the idle sequencer produces no result.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE && !q_valid) |=> !out_valid_r)
    else $error("result strobe without work");

  // No characters are shown while digits are still being worked out.
  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> !out_valid_r)
    else $error("result strobe during division");

  // An error result stands alone and carries no character.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_last_r && out_char_r == urf_pkg::CH_NUL &&
                                      out_len_r == '0))
    else $error("malformed error result");

  // The queue is drained only when the back end is free.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == B_IDLE || state_r == B_DIV))
    else $error("queue popped while busy");
`endif

endmodule

>>> tb/sv/urf_text_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and register channels of the formatter. Every
// accepted item is turned into the characters it should print, and every
// result strobe is compared with the oldest character still owed.
module urf_text_checker
  import urf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [VALUE_W-1:0]   in_value,
  input  logic [RADIX_W-1:0]   in_radix,
  input  logic [LEN_W-1:0]     in_field_width,
  input  logic                 in_left_justify,
  input  logic                 in_zero_pad,
  input  logic                 in_alt_prefix,
  input  logic                 out_valid,
  input  logic [CHAR_W-1:0]    out_char,
  input  logic                 out_last,
  input  logic [LEN_W-1:0]     out_total_length,
  input  logic                 out_error,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data,
  output int                   mismatches,
  output int                   pending
);

  localparam int TEXT_MAX  = DEF_MAX_WIDTH;
  localparam int RADIX_MAX = DEF_MAX_RADIX;

  // Built-in digit symbols, symbol 0 in the top byte of each string.
  localparam logic [8*16-1:0] LOWER_SYMS = "0123456789abcdef";
  localparam logic [8*16-1:0] UPPER_SYMS = "0123456789ABCDEF";

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic              err;
  } char_result_t;

  // Characters still owed by the block, oldest first.
  char_result_t expected_chars[$];

  // Our own copy of the custom symbol table.
  logic [VALUE_W-1:0] sym_low;
  logic [VALUE_W-1:0] sym_high;
  logic [RADIX_W-1:0] sym_count;

  // Works out the printed text of one conversion item and queues its characters.
  task automatic predict_conversion(input logic [CMD_W-1:0] cmd,
                                    input logic [VALUE_W-1:0] value,
                                    input logic [RADIX_W-1:0] radix_in,
                                    input logic [LEN_W-1:0] width_in,
                                    input logic lj, input logic zp, input logic alt);
    logic [CHAR_W-1:0] digits[64];
    logic [CHAR_W-1:0] text[$];
    logic [CHAR_W-1:0] pre1;
    logic [VALUE_W-1:0] rest;
    int unsigned base, nd, np, fw, size, total, pad, emit, d, i;
    char_result_t res;

    base = (cmd == CMD_CUSTOM) ? int'(sym_count) : int'(radix_in);
    res.ch   = CH_NUL;
    res.last = 1'b1;
    res.len  = '0;
    res.err  = 1'b1;

    // Unknown conversions and unusable bases give one error character.
    if (cmd > CMD_CUSTOM || base < 2 || base > RADIX_MAX) begin
      expected_chars.push_back(res);
      return;
    end

    // Digits come out least significant first; zero still gives one digit.
    rest = value;
    nd = 0;
    do begin
      d = int'(rest % base);
      if (cmd == CMD_CUSTOM) begin
        digits[nd] = (d < 8) ? sym_low[8*d +: 8] : sym_high[8*(d-8) +: 8];
      end else if (cmd == CMD_HEX_UPPER) begin
        digits[nd] = UPPER_SYMS[8*(15-d) +: 8];
      end else begin
        digits[nd] = LOWER_SYMS[8*(15-d) +: 8];
      end
      nd++;
      rest = rest / base;
    end while (rest != 0 && nd < 64);

    // Pointers always carry 0x; octal and hex only on request and for nonzero values, octal as a lone 0.
    np = 0;
    pre1 = CH_LOWER_X;
    if (cmd == CMD_POINTER || (alt && value != 0)) begin
      if (cmd == CMD_OCT) begin
        np = 1;
      end else if (cmd == CMD_HEX_LOWER || cmd == CMD_POINTER) begin
        np = 2;
      end else if (cmd == CMD_HEX_UPPER) begin
        np = 2;
        pre1 = CH_UPPER_X;
      end
    end

    fw = (width_in > TEXT_MAX) ? TEXT_MAX : int'(width_in);
    size = nd + np;
    total = (size > fw) ? size : fw;
    pad = total - size;

    // Lay out padding, prefix and digits; left justify forces trailing spaces.
    if (!lj && !zp) for (i = 0; i < pad; i++) text.push_back(CH_SPACE);
    if (np >= 1) text.push_back(CH_ZERO);
    if (np >= 2) text.push_back(pre1);
    if (!lj && zp) for (i = 0; i < pad; i++) text.push_back(CH_ZERO);
    for (i = nd; i > 0; i--) text.push_back(digits[i-1]);
    if (lj) for (i = 0; i < pad; i++) text.push_back(CH_SPACE);

    // Text beyond the widest field is cut off.
    emit = (text.size() > TEXT_MAX) ? TEXT_MAX : text.size();
    for (i = 0; i < emit; i++) begin
      res.ch   = text[i];
      res.last = (i + 1 == emit);
      res.len  = (i + 1 == emit) ? LEN_W'(emit) : '0;
      res.err  = 1'b0;
      expected_chars.push_back(res);
    end
  endtask

  // Compares one result strobe with the oldest owed character.
  task automatic check_char();
    char_result_t want;
    if (expected_chars.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: char %h last %b length %0d error %b",
               $time, out_char, out_last, out_total_length, out_error);
    end else begin
      want = expected_chars.pop_front();
      if (out_char !== want.ch || out_last !== want.last ||
          out_total_length !== want.len || out_error !== want.err) begin
        mismatches++;
        $display("%0t: expected char %h last %b length %0d error %b, got %h %b %0d %b",
                 $time, want.ch, want.last, want.len, want.err,
                 out_char, out_last, out_total_length, out_error);
      end
    end
  endtask

  // Everything is sampled at the rising edge, before the block's outputs move.
  always @(posedge clk) begin
    if (!rst_n) begin
      sym_low = '0;
      sym_high = '0;
      sym_count = '0;
      expected_chars.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYM_LOW:  sym_low = cfg_data;
          CFG_SYM_HIGH: sym_high = cfg_data;
          CFG_RADIX:    sym_count = cfg_data[RADIX_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_conversion(in_cmd, in_value, in_radix, in_field_width,
                           in_left_justify, in_zero_pad, in_alt_prefix);
      end
      if (out_valid) begin
        check_char();
      end
    end
    pending = expected_chars.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import urf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 600;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     in_cmd = '0;
  logic [VALUE_W-1:0]   in_value = '0;
  logic [RADIX_W-1:0]   in_radix = '0;
  logic [LEN_W-1:0]     in_field_width = '0;
  logic                 in_left_justify = 1'b0;
  logic                 in_zero_pad = 1'b0;
  logic                 in_alt_prefix = 1'b0;
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;
  logic [LEN_W-1:0]     out_total_length;
  logic                 out_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VALUE_W-1:0]   cfg_data = '0;

  int mismatch_count;
  int chars_owed;
  int cycle_count = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  unsigned_radix_formatter i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_value(in_value), .in_radix(in_radix),
    .in_field_width(in_field_width), .in_left_justify(in_left_justify),
    .in_zero_pad(in_zero_pad), .in_alt_prefix(in_alt_prefix),
    .out_valid(out_valid), .out_char(out_char), .out_last(out_last),
    .out_total_length(out_total_length), .out_error(out_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  urf_text_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_value(in_value), .in_radix(in_radix),
    .in_field_width(in_field_width), .in_left_justify(in_left_justify),
    .in_zero_pad(in_zero_pad), .in_alt_prefix(in_alt_prefix),
    .out_valid(out_valid), .out_char(out_char), .out_last(out_last),
    .out_total_length(out_total_length), .out_error(out_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(mismatch_count), .pending(chars_owed)
  );

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Presents one conversion item and returns at the edge that accepts it.
  task automatic send_conv(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                           input logic [RADIX_W-1:0] radix, input logic [LEN_W-1:0] width,
                           input logic lj, input logic zp, input logic alt);
    logic stalled;
    start <= 1'b1;
    in_cmd <= cmd;
    in_value <= value;
    in_radix <= radix;
    in_field_width <= width;
    in_left_justify <= lj;
    in_zero_pad <= zp;
    in_alt_prefix <= alt;
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
  endtask

  // Sometimes drops start for a burst of idle cycles.
  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic issue_conv(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                            input logic [RADIX_W-1:0] radix, input logic [LEN_W-1:0] width,
                            input logic lj, input logic zp, input logic alt);
    send_conv(cmd, value, radix, width, lj, zp, alt);
    idle_burst();
  endtask

  // Writes one register; valid stays high for the next write of a burst.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    logic ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  // Loads the whole custom symbol table while the block is idle.
  task automatic load_table(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                            input logic [RADIX_W-1:0] count);
    write_reg(CFG_SYM_LOW, lo);
    write_reg(CFG_SYM_HIGH, hi);
    write_reg(CFG_RADIX, count);
    cfg_valid <= 1'b0;
  endtask

  // Stops issuing and waits until every owed character has arrived.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (chars_owed != 0);
    @(posedge clk);
  endtask

  // One random item: mostly legal conversions with random content, some noise.
  task automatic random_conv();
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic [LEN_W-1:0]   width;
    cmd = ($urandom_range(0, 19) == 0) ? CMD_W'($urandom_range(6, 7))
                                       : CMD_W'($urandom_range(0, 5));
    case ($urandom_range(0, 5))
      0: value = '0;
      1: value = VALUE_W'($urandom_range(1, 255));
      2: value = {$urandom, $urandom};
      3: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      4: value = '1;
      default: value = VALUE_W'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0: radix = RADIX_W'($urandom_range(0, 1));
      1: radix = RADIX_W'($urandom_range(17, 31));
      2, 3: radix = 5'd8;
      4, 5: radix = 5'd10;
      6, 7: radix = 5'd16;
      default: radix = RADIX_W'($urandom_range(2, 16));
    endcase
    case ($urandom_range(0, 7))
      6: width = LEN_W'($urandom_range(25, 64));
      7: width = LEN_W'($urandom_range(65, 127));
      default: width = LEN_W'($urandom_range(0, 24));
    endcase
    issue_conv(cmd, value, radix, width, 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    int p;
    logic [VALUE_W-1:0] lo, hi;
    logic [RADIX_W-1:0] count;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items with the table still at its reset value.
    issue_conv(CMD_OCT, 64'd0, 5'd8, 7'd0, 1'b0, 1'b0, 1'b1);
    issue_conv(CMD_OCT, 64'd8, 5'd8, 7'd6, 1'b0, 1'b1, 1'b1);
    issue_conv(CMD_DEC, '1, 5'd10, 7'd0, 1'b0, 1'b0, 1'b0);
    issue_conv(CMD_DEC, 64'd123, 5'd10, 7'd5, 1'b0, 1'b1, 1'b1);
    issue_conv(CMD_HEX_LOWER, 64'hdeadbeef, 5'd16, 7'd20, 1'b0, 1'b1, 1'b1);
    issue_conv(CMD_HEX_UPPER, '1, 5'd16, 7'd30, 1'b1, 1'b0, 1'b1);
    issue_conv(CMD_HEX_UPPER, 64'hab, 5'd16, 7'd8, 1'b1, 1'b1, 1'b1);
    issue_conv(CMD_POINTER, 64'd0, 5'd16, 7'd10, 1'b0, 1'b0, 1'b0);
    issue_conv(CMD_POINTER, '1, 5'd16, 7'd64, 1'b0, 1'b1, 1'b0);
    issue_conv(CMD_HEX_LOWER, 64'h1234, 5'd16, 7'd127, 1'b0, 1'b0, 1'b0);
    issue_conv(CMD_DEC, 64'd7, 5'd10, 7'd65, 1'b1, 1'b0, 1'b0);
    issue_conv(CMD_OCT, '1, 5'd2, 7'd0, 1'b0, 1'b0, 1'b1);
    issue_conv(CMD_POINTER, '1, 5'd2, 7'd3, 1'b0, 1'b0, 1'b0);
    issue_conv(CMD_DEC, 64'd55, 5'd0, 7'd4, 1'b0, 1'b0, 1'b0);
    issue_conv(CMD_HEX_LOWER, 64'd55, 5'd1, 7'd4, 1'b0, 1'b0, 1'b0);
    issue_conv(CMD_OCT, 64'd55, 5'd17, 7'd4, 1'b0, 1'b0, 1'b0);
    issue_conv(CMD_DEC, 64'd55, 5'd31, 7'd4, 1'b0, 1'b0, 1'b0);
    issue_conv(3'd6, 64'd1, 5'd10, 7'd0, 1'b0, 1'b0, 1'b0);
    issue_conv(3'd7, 64'd1, 5'd10, 7'd0, 1'b0, 1'b0, 1'b0);
    issue_conv(CMD_CUSTOM, 64'd9, 5'd10, 7'd0, 1'b0, 1'b0, 1'b0);
    drain();

    // Directed custom conversions: a full table, a binary one, then bad counts.
    load_table(64'h3736353433323130, 64'h4645444342413938, 5'd16);
    issue_conv(CMD_CUSTOM, '1, 5'd0, 7'd0, 1'b0, 1'b0, 1'b1);
    issue_conv(CMD_CUSTOM, 64'd0, 5'd0, 7'd3, 1'b0, 1'b1, 1'b0);
    drain();
    load_table('1, 64'd0, 5'd2);
    issue_conv(CMD_CUSTOM, '1, 5'd16, 7'd0, 1'b0, 1'b0, 1'b0);
    drain();
    load_table(64'h3736353433323130, '1, 5'd1);
    issue_conv(CMD_CUSTOM, 64'd5, 5'd10, 7'd0, 1'b0, 1'b0, 1'b0);
    drain();
    load_table(64'h3736353433323130, '1, 5'd17);
    issue_conv(CMD_CUSTOM, 64'd5, 5'd10, 7'd0, 1'b0, 1'b0, 1'b0);
    drain();

    // Random phases, each under its own symbol table; the last one runs without gaps.
    for (p = 0; p < 6; p++) begin
      quiet = (p == 5);
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (p)
        0: count = 5'd16;
        1: begin
          lo = '0;
          hi = '1;
          count = 5'd2;
        end
        2: count = RADIX_W'($urandom_range(3, 15));
        3: count = RADIX_W'($urandom_range(0, 1));
        4: count = RADIX_W'($urandom_range(17, 31));
        default: count = RADIX_W'($urandom_range(2, 16));
      endcase
      load_table(lo, hi, count);
      repeat (24) random_conv();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
